@@ hdl/ubh_pkg.sv @@
// ----------------------------------------------------------------------------
// ubh_pkg
// Shared types, constants and helpers for the UDP/IPv4 frame header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ubh_pkg;

    localparam int unsigned OFFSET_W     = 13;
    localparam int unsigned COUNT_W      = 13;
    localparam int unsigned HDR_IDX_W    = 5;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 48;

    localparam logic [COUNT_W-1:0]   MAX_PAYLOAD    = 13'd4096;
    localparam logic [OFFSET_W-1:0]  PAYLOAD_BASE   = 13'd42;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX   = 5'd20;

    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] IP_TTL_PROTO   = {IP_TTL, IP_PROTO_UDP};
    localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;

    localparam logic [15:0] RST_SOURCE_PORT = 16'd49152;
    localparam logic [47:0] RST_DEST_MAC    = 48'hffff_ffff_ffff;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEST_MAC    = 3'd0,
        CFG_SOURCE_MAC  = 3'd1,
        CFG_SOURCE_IP   = 3'd2,
        CFG_DEST_IP     = 3'd3,
        CFG_DEST_PORT   = 3'd4,
        CFG_SOURCE_PORT = 3'd5,
        CFG_IP_IDENT    = 3'd6
    } cfg_index_e;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] frame_offset;
        logic [15:0]         frame_data;
        logic                two_bytes;
        logic                frame_done;
    } out_word_t;

    // register file contents plus partial checksums that depend on it only
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [15:0] ip_ident;
        logic [15:0] ip_part;
        logic [15:0] udp_part;
    } cfg_t;

    // latched datagram totals and the header word being emitted
    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [15:0]          sum;
        logic [HDR_IDX_W-1:0] idx;
    } hdr_req_t;

    // ones'-complement fold of a wide binary sum down to 16 bits
    function automatic logic [15:0] oc_fold(input logic [19:0] s);
        logic [16:0] t;
        logic [16:0] r;
        t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        r = {1'b0, t[15:0]} + {16'd0, t[16]};
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/ubh_cfg.sv @@
// ----------------------------------------------------------------------------
// ubh_cfg
// Configuration registers and the partial checksums that follow from them.
// ----------------------------------------------------------------------------
`default_nettype none

module ubh_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ubh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ubh_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ubh_pkg::cfg_t                       cfg
);
    import ubh_pkg::*;

    logic [47:0] dest_mac_reg;
    logic [47:0] source_mac_reg;
    logic [31:0] source_ip_reg;
    logic [31:0] dest_ip_reg;
    logic [15:0] dest_port_reg;
    logic [15:0] source_port_reg;
    logic [15:0] ip_ident_reg;

    logic [17:0] addr_sum_reg;
    logic [17:0] port_sum_reg;
    logic [16:0] ip_fix_reg;
    logic [15:0] ip_part_reg;
    logic [15:0] udp_part_reg;

    logic [17:0] addr_sum_next;
    logic [17:0] port_sum_next;
    logic [16:0] ip_fix_next;
    logic [15:0] ip_part_next;
    logic [15:0] udp_part_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_mac_reg    <= RST_DEST_MAC;
            source_mac_reg  <= '0;
            source_ip_reg   <= '0;
            dest_ip_reg     <= '0;
            dest_port_reg   <= '0;
            source_port_reg <= RST_SOURCE_PORT;
            ip_ident_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEST_MAC:    dest_mac_reg    <= cfg_data;
                CFG_SOURCE_MAC:  source_mac_reg  <= cfg_data;
                CFG_SOURCE_IP:   source_ip_reg   <= cfg_data[31:0];
                CFG_DEST_IP:     dest_ip_reg     <= cfg_data[31:0];
                CFG_DEST_PORT:   dest_port_reg   <= cfg_data[15:0];
                CFG_SOURCE_PORT: source_port_reg <= cfg_data[15:0];
                CFG_IP_IDENT:    ip_ident_reg    <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // two register stages: raw sums, then folded partial checksums
    always_comb
    begin
        addr_sum_next = {2'b0, source_ip_reg[31:16]} + {2'b0, source_ip_reg[15:0]}
                      + {2'b0, dest_ip_reg[31:16]} + {2'b0, dest_ip_reg[15:0]};
        port_sum_next = {2'b0, source_port_reg} + {2'b0, dest_port_reg}
                      + {10'd0, IP_PROTO_UDP};
        ip_fix_next   = {1'b0, ip_ident_reg} + {1'b0, IP_VER_IHL_TOS}
                      + {1'b0, IP_TTL_PROTO};
        ip_part_next  = oc_fold({2'b0, addr_sum_reg} + {3'b0, ip_fix_reg});
        udp_part_next = oc_fold({2'b0, addr_sum_reg} + {2'b0, port_sum_reg});
    end

    always_ff @(posedge clk)
    begin
        addr_sum_reg <= addr_sum_next;
        port_sum_reg <= port_sum_next;
        ip_fix_reg   <= ip_fix_next;
        ip_part_reg  <= ip_part_next;
        udp_part_reg <= udp_part_next;
    end

    always_comb
    begin
        cfg.dest_mac    = dest_mac_reg;
        cfg.source_mac  = source_mac_reg;
        cfg.source_ip   = source_ip_reg;
        cfg.dest_ip     = dest_ip_reg;
        cfg.dest_port   = dest_port_reg;
        cfg.source_port = source_port_reg;
        cfg.ip_ident    = ip_ident_reg;
        cfg.ip_part     = ip_part_reg;
        cfg.udp_part    = udp_part_reg;
    end

endmodule

`default_nettype wire

@@ hdl/ubh_hdr.sv @@
// ----------------------------------------------------------------------------
// ubh_hdr
// Header checksums and selection of the header halfword being emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module ubh_hdr
(
    input  wire logic              clk,
    input  wire ubh_pkg::cfg_t     cfg,
    input  wire ubh_pkg::hdr_req_t req,
    output logic [15:0]            hdr_word
);
    import ubh_pkg::*;

    logic [15:0] tot_len;
    logic [15:0] udp_len;
    logic [15:0] ip_ck_reg;
    logic [15:0] udp_ck_reg;
    logic [15:0] ip_ck_next;
    logic [15:0] udp_ck_next;

    always_comb
    begin
        tot_len     = {3'b0, req.count} + IP_UDP_HDR_LEN;
        udp_len     = {3'b0, req.count} + UDP_HDR_LEN;
        ip_ck_next  = ~oc_fold({4'b0, cfg.ip_part} + {4'b0, tot_len});
        // UDP length appears twice: once in the pseudo-header, once in the header
        udp_ck_next = ~oc_fold({4'b0, req.sum} + {4'b0, cfg.udp_part}
                               + {3'b0, udp_len, 1'b0});
    end

    // totals are latched before the checksum words go out
    always_ff @(posedge clk)
    begin
        ip_ck_reg  <= ip_ck_next;
        udp_ck_reg <= udp_ck_next;
    end

    always_comb
    begin
        unique case (req.idx)
            5'd0:    hdr_word = cfg.dest_mac[47:32];
            5'd1:    hdr_word = cfg.dest_mac[31:16];
            5'd2:    hdr_word = cfg.dest_mac[15:0];
            5'd3:    hdr_word = cfg.source_mac[47:32];
            5'd4:    hdr_word = cfg.source_mac[31:16];
            5'd5:    hdr_word = cfg.source_mac[15:0];
            5'd6:    hdr_word = ETH_TYPE_IPV4;
            5'd7:    hdr_word = IP_VER_IHL_TOS;
            5'd8:    hdr_word = tot_len;
            5'd9:    hdr_word = cfg.ip_ident;
            5'd10:   hdr_word = 16'd0;
            5'd11:   hdr_word = IP_TTL_PROTO;
            5'd12:   hdr_word = ip_ck_reg;
            5'd13:   hdr_word = cfg.source_ip[31:16];
            5'd14:   hdr_word = cfg.source_ip[15:0];
            5'd15:   hdr_word = cfg.dest_ip[31:16];
            5'd16:   hdr_word = cfg.dest_ip[15:0];
            5'd17:   hdr_word = cfg.source_port;
            5'd18:   hdr_word = cfg.dest_port;
            5'd19:   hdr_word = udp_len;
            5'd20:   hdr_word = udp_ck_reg;
            default: hdr_word = 16'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ubh_seq.sv @@
// ----------------------------------------------------------------------------
// ubh_seq
// Input register, running payload sum and count, and header word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ubh_seq
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ubh_pkg::in_word_t in_word,
    input  wire logic              advance,
    input  wire logic [15:0]       hdr_word,
    output ubh_pkg::hdr_req_t      req,
    output logic                   gen_valid,
    output ubh_pkg::out_word_t     gen_word
);
    import ubh_pkg::*;

    logic                 in_valid_reg;
    in_word_t             in_data_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [15:0]          sum_reg;
    logic                 hdr_active_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;
    logic [COUNT_W-1:0]   hdr_count_reg;
    logic [15:0]          hdr_sum_reg;

    logic                 consume;
    logic                 room;
    logic                 keep;
    logic [15:0]          addend;
    logic [16:0]          raw_sum;
    logic [COUNT_W-1:0]   count_next;
    logic [15:0]          sum_next;

    always_comb
    begin
        consume  = in_valid_reg && !hdr_active_reg && advance;
        room     = (count_reg != MAX_PAYLOAD);
        keep     = consume && room;
        in_stall = in_valid_reg && !consume;

        // even index is the high byte of its halfword
        addend  = count_reg[0] ? {8'd0, in_data_reg.payload_byte}
                               : {in_data_reg.payload_byte, 8'd0};
        raw_sum = {1'b0, sum_reg} + {1'b0, addend};
        count_next = keep ? count_reg + 13'd1 : count_reg;
        sum_next   = keep ? (raw_sum[15:0] + {15'd0, raw_sum[16]}) : sum_reg;

        req.count = hdr_count_reg;
        req.sum   = hdr_sum_reg;
        req.idx   = hdr_idx_reg;

        if (hdr_active_reg)
        begin
            gen_valid             = 1'b1;
            gen_word.frame_offset = {7'd0, hdr_idx_reg, 1'b0};
            gen_word.frame_data   = hdr_word;
            gen_word.two_bytes    = 1'b1;
            gen_word.frame_done   = (hdr_idx_reg == HDR_LAST_IDX);
        end
        else
        begin
            gen_valid             = in_valid_reg && room;
            gen_word.frame_offset = PAYLOAD_BASE + count_reg;
            gen_word.frame_data   = {8'd0, in_data_reg.payload_byte};
            gen_word.two_bytes    = 1'b0;
            gen_word.frame_done   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_word;
        end
        if (consume && in_data_reg.final_byte)
        begin
            hdr_count_reg <= count_next;
            hdr_sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            hdr_active_reg <= 1'b0;
            hdr_idx_reg    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                if (in_data_reg.final_byte)
                begin
                    // start header, clear totals for the next datagram
                    count_reg      <= '0;
                    sum_reg        <= '0;
                    hdr_active_reg <= 1'b1;
                    hdr_idx_reg    <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                end
            end
            else if (hdr_active_reg && advance)
            begin
                if (hdr_idx_reg == HDR_LAST_IDX)
                begin
                    hdr_active_reg <= 1'b0;
                    hdr_idx_reg    <= '0;
                end
                else
                begin
                    hdr_idx_reg <= hdr_idx_reg + 5'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/ubh_out.sv @@
// ----------------------------------------------------------------------------
// ubh_out
// Result register on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ubh_out
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               gen_valid,
    input  wire ubh_pkg::out_word_t gen_word,
    output logic                    advance,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ubh_pkg::out_word_t      out_word
);
    import ubh_pkg::*;

    logic      out_valid_reg;
    out_word_t out_word_reg;

    // load whenever the held word is empty or leaving this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= gen_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && gen_valid)
        begin
            out_word_reg <= gen_word;
        end
    end

endmodule

`default_nettype wire

@@ hdl/udp_ipv4_frame_header_builder_core.sv @@
// ----------------------------------------------------------------------------
// udp_ipv4_frame_header_builder_core
// Builds a UDP/IPv4/Ethernet frame: echoes payload, then emits the header.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle while the output is not stalled, and
// each comes out at frame offset 42 plus its index while a ones'-complement
// sum and a byte count run along. After the byte marked final, 21 header
// halfwords for offsets 0..40 follow one per cycle unless the output stalls,
// the last flagged frame_done. The input stalls while the header goes out,
// which the single header word sequencer sets. Bytes beyond 4096 are dropped.
// Bytes pass the input register, then the output register. Configuration
// writes take effect for a frame whose final byte is accepted later.
`default_nettype none

module udp_ipv4_frame_header_builder_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ubh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ubh_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire ubh_pkg::in_word_t               in_word,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output ubh_pkg::out_word_t                   out_word
);
    import ubh_pkg::*;

    cfg_t      cfg;
    hdr_req_t  req;
    logic      advance;
    logic      gen_valid;
    out_word_t gen_word;
    logic [15:0] hdr_word;

    ubh_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ubh_hdr u_hdr
    (
        .clk      (clk),
        .cfg      (cfg),
        .req      (req),
        .hdr_word (hdr_word)
    );

    ubh_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .advance   (advance),
        .hdr_word  (hdr_word),
        .req       (req),
        .gen_valid (gen_valid),
        .gen_word  (gen_word)
    );

    ubh_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .gen_valid (gen_valid),
        .gen_word  (gen_word),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire
